// File: src/g3mdu_pkg.sv
// ----------------------------------------------------------------------------
// Group-3 unary and multiply/divide unit package
// Shared codes, item and stage types used by the front, queue and back parts.
// ----------------------------------------------------------------------------
package g3mdu_pkg;

  localparam int unsigned DivSteps = 16;

  localparam logic [2:0] ACT_TEST0 = 3'd0;
  localparam logic [2:0] ACT_TEST1 = 3'd1;
  localparam logic [2:0] ACT_NOT   = 3'd2;
  localparam logic [2:0] ACT_NEG   = 3'd3;
  localparam logic [2:0] ACT_MUL   = 3'd4;
  localparam logic [2:0] ACT_IMUL  = 3'd5;
  localparam logic [2:0] ACT_DIV   = 3'd6;
  localparam logic [2:0] ACT_IDIV  = 3'd7;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_RM   = 2'd1;
  localparam logic [1:0] TGT_ACC  = 2'd2;

  localparam logic [1:0] FW_NONE  = 2'd0;
  localparam logic [1:0] FW_CO    = 2'd1;
  localparam logic [1:0] FW_ALL   = 2'd2;

  typedef enum logic [2:0] {
    OP_TEST, OP_NOT, OP_NEG, OP_MUL, OP_IMUL, OP_DIV, OP_IDIV
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        word;
    logic [15:0] rm;
    logic [15:0] acc;
    logic [15:0] imm;
    logic [31:0] dvd;
    logic [15:0] dvs;
    logic        nq;
    logic        nr;
    logic        perr;
  } item_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    logic [1:0]  target;
    logic        derr;
    logic [1:0]  fw;
    logic        cf;
    logic        of;
    logic        sf;
    logic        zf;
    logic        pf;
    logic        af;
  } res_t;

  typedef struct packed {
    logic        valid;
    op_e         op;
    logic        word;
    res_t        res;
    logic [31:0] prod;
    logic [15:0] rem;
    logic [15:0] wrk;
    logic [15:0] dvs;
    logic        nq;
    logic        nr;
    logic        perr;
  } stage_t;

endpackage

// File: src/g3mdu_front.sv
// ----------------------------------------------------------------------------
// Group-3 unit front end
// Accepts instructions, decodes the operation and prepares divider operands.
// ----------------------------------------------------------------------------
module g3mdu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [3:0]          user_i,
  input  logic [63:0]         data_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output g3mdu_pkg::item_t    item_o
);
  import g3mdu_pkg::*;

  item_t       item_d, item_q;
  logic        valid_q;
  logic        word, nd, nv, is_idiv;
  logic [2:0]  act;
  logic [15:0] mask, rm, acc, dx, imm, av;
  logic [31:0] dvd, ad;

  assign act  = user_i[2:0];
  assign word = user_i[3];
  assign mask = word ? 16'hFFFF : 16'h00FF;
  assign rm   = data_i[15:0] & mask;
  assign acc  = data_i[31:16];
  assign dx   = data_i[47:32];
  assign imm  = data_i[63:48] & mask;
  assign dvd  = word ? {dx, acc} : {16'h0000, acc};
  assign is_idiv = (act == ACT_IDIV);
  assign nd   = is_idiv & (word ? dvd[31] : dvd[15]);
  assign nv   = is_idiv & (word ? rm[15] : rm[7]);
  assign ad   = nd ? (word ? (32'd0 - dvd) : {16'h0000, 16'd0 - acc}) : dvd;
  assign av   = nv ? ((16'd0 - rm) & mask) : rm;

  always_comb begin
    item_d.word = word;
    item_d.rm   = rm;
    item_d.acc  = acc & mask;
    item_d.imm  = imm;
    item_d.dvd  = ad;
    item_d.dvs  = av;
    item_d.nq   = nd ^ nv;
    item_d.nr   = nd;
    item_d.perr = (ad[31:16] >= av);
    unique case (act) inside
      ACT_TEST0, ACT_TEST1: item_d.op = OP_TEST;
      ACT_NOT:              item_d.op = OP_NOT;
      ACT_NEG:              item_d.op = OP_NEG;
      ACT_MUL:              item_d.op = OP_MUL;
      ACT_IMUL:             item_d.op = OP_IMUL;
      ACT_DIV:              item_d.op = OP_DIV;
      default:              item_d.op = OP_IDIV;
    endcase
  end

  assign ready_o      = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// File: src/g3mdu_queue.sv
// ----------------------------------------------------------------------------
// Group-3 unit decoupling queue
// Two-entry queue of decoded instructions between the front and back parts.
// ----------------------------------------------------------------------------
module g3mdu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  g3mdu_pkg::item_t    in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output g3mdu_pkg::item_t    out_item_o
);
  import g3mdu_pkg::*;

  item_t      entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = entry_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q)) else $error("queue pointers");
`endif

endmodule

// File: src/g3mdu_back.sv
// ----------------------------------------------------------------------------
// Group-3 unit back end
// Executes the operation: logic ops and multiplier up front, then a pipelined
// restoring divider with one quotient bit per stage, then the result register.
// ----------------------------------------------------------------------------
module g3mdu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  g3mdu_pkg::item_t    item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output g3mdu_pkg::res_t     res_o
);
  import g3mdu_pkg::*;

  stage_t pipe_q [DivSteps+1];
  stage_t first_d;
  stage_t step_d [DivSteps];
  res_t   out_d, out_q;
  logic   out_valid_q;
  logic   adv;

  logic signed [16:0] ma, mb;
  logic signed [33:0] mprod;
  logic [15:0] neg_r, logic_r;

  assign adv = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    ma = (item_i.op == OP_IMUL)
       ? (item_i.word ? {item_i.acc[15], item_i.acc} : {{9{item_i.acc[7]}}, item_i.acc[7:0]})
       : {1'b0, item_i.acc};
    mb = (item_i.op == OP_IMUL)
       ? (item_i.word ? {item_i.rm[15], item_i.rm} : {{9{item_i.rm[7]}}, item_i.rm[7:0]})
       : {1'b0, item_i.rm};
    mprod = ma * mb;
    neg_r = (16'd0 - item_i.rm) & (item_i.word ? 16'hFFFF : 16'h00FF);

    first_d       = '0;
    first_d.valid = in_valid_i;
    first_d.op    = item_i.op;
    first_d.word  = item_i.word;
    first_d.prod  = mprod[31:0];
    first_d.rem   = item_i.dvd[31:16];
    first_d.wrk   = item_i.dvd[15:0];
    first_d.dvs   = item_i.dvs;
    first_d.nq    = item_i.nq;
    first_d.nr    = item_i.nr;
    first_d.perr  = item_i.perr;
    logic_r       = '0;
    case (item_i.op)
      OP_TEST: begin
        logic_r           = item_i.rm & item_i.imm;
        first_d.res.fw    = FW_ALL;
      end
      OP_NOT: begin
        first_d.res.low    = ~item_i.rm & (item_i.word ? 16'hFFFF : 16'h00FF);
        first_d.res.target = TGT_RM;
      end
      OP_NEG: begin
        logic_r            = neg_r;
        first_d.res.target = TGT_RM;
        first_d.res.fw     = FW_ALL;
        first_d.res.cf     = (item_i.rm != 16'd0);
        first_d.res.of     = item_i.word ? (item_i.rm == 16'h8000) : (item_i.rm == 16'h0080);
        first_d.res.af     = (item_i.rm[3:0] != 4'd0);
      end
      default: ;
    endcase
    if (item_i.op == OP_TEST || item_i.op == OP_NEG) begin
      first_d.res.low = logic_r;
      first_d.res.sf  = item_i.word ? logic_r[15] : logic_r[7];
      first_d.res.zf  = (logic_r == 16'd0);
      first_d.res.pf  = ~^logic_r[7:0];
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [16:0] trial;
    logic        take;
    always_comb begin
      trial     = {pipe_q[g].rem, pipe_q[g].wrk[15]};
      take      = (trial >= {1'b0, pipe_q[g].dvs});
      step_d[g] = pipe_q[g];
      step_d[g].rem = take ? 16'(trial - {1'b0, pipe_q[g].dvs}) : trial[15:0];
      step_d[g].wrk = {pipe_q[g].wrk[14:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DivSteps; i++) pipe_q[i] <= '0;
    end else if (adv) begin
      pipe_q[0] <= first_d;
      for (int i = 0; i < DivSteps; i++) pipe_q[i+1] <= step_d[i];
    end
  end

  stage_t      fin;
  logic [15:0] q, lim, qn, rn, mask;
  logic        ovf, err;

  always_comb begin
    fin   = pipe_q[DivSteps];
    out_d = fin.res;
    mask  = fin.word ? 16'hFFFF : 16'h00FF;
    q     = fin.wrk;
    if (fin.op == OP_DIV) begin
      lim = mask;
    end else if (fin.word) begin
      lim = fin.nq ? 16'h8000 : 16'h7FFF;
    end else begin
      lim = fin.nq ? 16'h0080 : 16'h007F;
    end
    err = fin.perr || (q > lim);
    qn  = (fin.nq ? (16'd0 - q) : q) & mask;
    rn  = (fin.nr ? (16'd0 - fin.rem) : fin.rem) & mask;
    if (fin.word) begin
      ovf = (fin.op == OP_MUL) ? (fin.prod[31:16] != 16'd0)
                               : (fin.prod[31:15] != {17{fin.prod[15]}});
    end else begin
      ovf = (fin.op == OP_MUL) ? (fin.prod[15:8] != 8'd0)
                               : (fin.prod[15:7] != {9{fin.prod[7]}});
    end
    case (fin.op) inside
      OP_MUL, OP_IMUL: begin
        out_d.low    = fin.prod[15:0] & mask;
        out_d.high   = fin.word ? fin.prod[31:16] : {8'h00, fin.prod[15:8]};
        out_d.target = TGT_ACC;
        out_d.fw     = FW_CO;
        out_d.cf     = ovf;
        out_d.of     = ovf;
      end
      OP_DIV, OP_IDIV: begin
        out_d = '0;
        if (err) begin
          out_d.derr = 1'b1;
        end else begin
          out_d.low    = qn;
          out_d.high   = rn;
          out_d.target = TGT_ACC;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.derr) |-> (out_q.target == TGT_NONE && out_q.fw == FW_NONE))
    else $error("divide error with writeback");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pipe_q[DivSteps].valid) && $stable(pipe_q[0].valid))
    else $error("pipeline moved while stalled");
`endif

endmodule

// File: src/x86_group3_unary_muldiv_unit.sv
// ----------------------------------------------------------------------------
// 8086 group-3 execute unit
// TEST, NOT, NEG, MUL, IMUL, DIV and IDIV in byte or word width.
// ----------------------------------------------------------------------------
// The unit accepts one instruction per clock unless the output stalls it, and
// returns one result per instruction, in order. Every instruction takes the
// same path: an input register, a two-entry queue, an operand stage with the
// multiplier, a sixteen-stage restoring divider that resolves one quotient
// bit per stage, and the result register. Divide errors are detected on the
// high dividend half before the divider and on the quotient range after it.
module x86_group3_unary_muldiv_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [3:0]  s_axis_tuser,  // action[2:0], word_size[3]
  input  logic [63:0] s_axis_tdata,  // rm_value, acc_value, high_value, imm_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [3:0]  m_axis_tuser,  // write_target[1:0], flags_written[3:2]
  output logic [39:0] m_axis_tdata   // low_result, high_result, divide_error,
                                     // carry, overflow, sign, zero, parity, adjust
);
  import g3mdu_pkg::*;

  item_t fr_item, q_item;
  logic  fr_valid, fr_ready, q_valid, q_ready;
  res_t  res;

  g3mdu_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .user_i(s_axis_tuser), .data_i(s_axis_tdata),
    .item_valid_o(fr_valid), .item_ready_i(fr_ready), .item_o(fr_item)
  );

  g3mdu_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fr_valid), .in_ready_o(fr_ready), .in_item_i(fr_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  g3mdu_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tuser = {res.fw, res.target};
  assign m_axis_tdata = {1'b0, res.af, res.pf, res.zf, res.sf, res.of, res.cf,
                         res.derr, res.high, res.low};

endmodule

// File: tb/sv/x86_group3_unary_muldiv_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the 8086 group-3 execute unit
// Drives TEST, NOT, NEG, MUL, IMUL, DIV and IDIV transactions at byte and
// word width with random idle cycles on both streams, predicts each result
// and compares it, field by field, with the result stream in order.
// ----------------------------------------------------------------------------
module x86_group3_unary_muldiv_unit_tb;
  import g3mdu_pkg::*;

  typedef struct {
    logic [2:0]  action;
    logic        word;
    logic [15:0] rm;
    logic [15:0] acc;
    logic [15:0] high;
    logic [15:0] imm;
  } instr_t;

  typedef struct {
    logic [15:0] low;
    logic [15:0] high;
    logic [1:0]  target;
    logic        derr;
    logic [1:0]  fw;
    logic        cf, of, sf, zf, pf, af;
  } outcome_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  class group3_scoreboard;
    outcome_t pending[$];

    function automatic outcome_t execute(instr_t t);
      outcome_t o;
      int unsigned bits, mask, sgn, rm, acc, imm, r, p, dvd, dsign, ad, av, q, rem;
      int signed a, b, s;
      bit err, ovf, nd, nv;
      o = '{default: 0};
      bits = t.word ? 16 : 8;
      mask = t.word ? 32'hFFFF : 32'hFF;
      sgn = t.word ? 32'h8000 : 32'h80;
      rm = t.rm & mask;
      imm = t.imm & mask;
      acc = t.acc & mask;
      case (t.action) inside
        ACT_TEST0, ACT_TEST1: begin
          r = rm & imm;
          o.low = 16'(r); o.fw = FW_ALL;
          o.sf = 1'((r >> (bits - 1)) & 1); o.zf = (r == 0); o.pf = ~^r[7:0];
        end
        ACT_NOT: begin
          o.low = 16'(~rm & mask); o.target = TGT_RM;
        end
        ACT_NEG: begin
          r = (0 - rm) & mask;
          o.low = 16'(r); o.target = TGT_RM; o.fw = FW_ALL;
          o.cf = (rm != 0); o.of = (rm == sgn); o.af = (rm[3:0] != 0);
          o.sf = 1'((r >> (bits - 1)) & 1); o.zf = (r == 0); o.pf = ~^r[7:0];
        end
        ACT_MUL, ACT_IMUL: begin
          if (t.action == ACT_MUL) begin
            p = acc * rm; ovf = p > mask;
          end else begin
            a = (acc & sgn) ? int'(acc) - int'(mask + 1) : int'(acc);
            b = (rm & sgn) ? int'(rm) - int'(mask + 1) : int'(rm);
            s = a * b;
            ovf = s > int'(sgn - 1) || s < -int'(sgn);
            p = s;
          end
          o.low = 16'(p & mask); o.high = 16'((p >> bits) & mask);
          o.target = TGT_ACC; o.fw = FW_CO; o.cf = ovf; o.of = ovf;
        end
        default: begin
          dvd = t.word ? {t.high, t.acc} : 32'(t.acc);
          dsign = t.word ? 32'h8000_0000 : 32'h8000;
          err = 0; q = 0; rem = 0;
          if (rm == 0) err = 1;
          else if (t.action == ACT_DIV) begin
            q = dvd / rm; rem = dvd % rm;
            if (q > mask) err = 1;
          end else begin
            nd = (dvd & dsign) != 0; nv = (rm & sgn) != 0;
            ad = nd ? (0 - dvd) & (t.word ? 32'hFFFF_FFFF : 32'hFFFF) : dvd;
            av = nv ? (0 - rm) & mask : rm;
            if (nd && ad == 0) ad = dsign;
            q = ad / av; rem = ad % av;
            if (nd != nv) begin
              if (q > sgn) err = 1;
              q = 0 - q;
            end else if (q > sgn - 1) err = 1;
            if (nd) rem = 0 - rem;
          end
          if (err) o.derr = 1;
          else begin
            o.low = 16'(q & mask); o.high = 16'(rem & mask); o.target = TGT_ACC;
          end
        end
      endcase
      return o;
    endfunction

    function void note_instr(instr_t t);
      pending.push_back(execute(t));
    endfunction

    task check_result(outcome_t g);
      outcome_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (g.low != w.low) report_mismatch("low_result", int'(g.low), int'(w.low));
      if (g.high != w.high) report_mismatch("high_result", int'(g.high), int'(w.high));
      if (g.target != w.target)
        report_mismatch("write_target", int'(g.target), int'(w.target));
      if (g.derr != w.derr) report_mismatch("divide_error", int'(g.derr), int'(w.derr));
      if (g.fw != w.fw) report_mismatch("flags_written", int'(g.fw), int'(w.fw));
      if (g.cf != w.cf) report_mismatch("carry_flag", int'(g.cf), int'(w.cf));
      if (g.of != w.of) report_mismatch("overflow_flag", int'(g.of), int'(w.of));
      if (g.sf != w.sf) report_mismatch("sign_flag", int'(g.sf), int'(w.sf));
      if (g.zf != w.zf) report_mismatch("zero_flag", int'(g.zf), int'(w.zf));
      if (g.pf != w.pf) report_mismatch("parity_flag", int'(g.pf), int'(w.pf));
      if (g.af != w.af) report_mismatch("adjust_flag", int'(g.af), int'(w.af));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [3:0]  s_axis_tuser = '0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [3:0]  m_axis_tuser;
  logic [39:0] m_axis_tdata;

  group3_scoreboard board = new();
  bit calm = 0;
  int idle_cycles = 0;

  x86_group3_unary_muldiv_unit DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    outcome_t g;
    if (m_axis_tvalid && m_axis_tready) begin
      g.target = m_axis_tuser[1:0]; g.fw = m_axis_tuser[3:2];
      {g.af, g.pf, g.zf, g.sf, g.of, g.cf, g.derr, g.high, g.low} = m_axis_tdata[38:0];
      board.check_result(g);
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 2000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 21);
  end

  task automatic send_instr(input instr_t t);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= {t.word, t.action};
    s_axis_tdata <= {t.imm, t.high, t.acc, t.rm};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_instr(t);
    @(negedge clk_i);
  endtask

  function automatic instr_t make_instr(logic [2:0] act, logic w, logic [15:0] rm,
                                        logic [15:0] acc, logic [15:0] hi,
                                        logic [15:0] imm);
    instr_t t;
    t.action = act; t.word = w; t.rm = rm; t.acc = acc; t.high = hi; t.imm = imm;
    return t;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0080;
      4: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    instr_t t;
    logic [15:0] v;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    send_instr(make_instr(ACT_TEST0, 1'b0, 16'hFFFF, 16'h0, 16'h0, 16'hFF80));
    send_instr(make_instr(ACT_TEST1, 1'b1, 16'h8000, 16'h0, 16'h0, 16'h0000));
    send_instr(make_instr(ACT_NOT, 1'b0, 16'hAA55, 16'h0, 16'h0, 16'h0));
    send_instr(make_instr(ACT_NOT, 1'b1, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_instr(make_instr(ACT_NEG, 1'b0, 16'h0080, 16'h0, 16'h0, 16'h0));
    send_instr(make_instr(ACT_NEG, 1'b1, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_instr(make_instr(ACT_NEG, 1'b1, 16'h8000, 16'h0, 16'h0, 16'h0));
    send_instr(make_instr(ACT_MUL, 1'b0, 16'h00FF, 16'h00FF, 16'h0, 16'h0));
    send_instr(make_instr(ACT_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0));
    send_instr(make_instr(ACT_IMUL, 1'b0, 16'h0080, 16'h0080, 16'h0, 16'h0));
    send_instr(make_instr(ACT_IMUL, 1'b1, 16'hFFFF, 16'h8000, 16'h0, 16'h0));
    send_instr(make_instr(ACT_IMUL, 1'b1, 16'hFFFF, 16'h0001, 16'h0, 16'h0));
    send_instr(make_instr(ACT_DIV, 1'b0, 16'h0000, 16'h1234, 16'h0, 16'h0));
    send_instr(make_instr(ACT_DIV, 1'b0, 16'h0001, 16'h0100, 16'h0, 16'h0));
    send_instr(make_instr(ACT_DIV, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0));
    send_instr(make_instr(ACT_DIV, 1'b1, 16'h0002, 16'h0000, 16'hFFFF, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b0, 16'h0002, 16'hFF00, 16'h0, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b0, 16'h00FF, 16'h8000, 16'h0, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b1, 16'h0001, 16'h8000, 16'hFFFF, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b1, 16'hFFFF, 16'h8000, 16'h0000, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b1, 16'h0003, 16'hFFF9, 16'hFFFF, 16'h0));
    send_instr(make_instr(ACT_IDIV, 1'b1, 16'h0000, 16'h0001, 16'h0, 16'h0));
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    for (int i = 0; i < 900; i++) begin
      calm = (i >= 300 && i < 400);
      t = make_instr(3'($urandom_range(7)), 1'($urandom_range(1)), pick_value(),
                     pick_value(), pick_value(), pick_value());
      // Keep most divisions in range: nonzero divisor, high dividend half zero or all ones.
      if (t.action >= ACT_DIV && $urandom_range(3) != 0) begin
        v = t.word ? t.rm : {8'h00, t.rm[7:0]};
        if (v == 0) t.rm = t.rm | 16'h0001;
        if (t.word) t.high = $urandom_range(3) == 0 ? 16'hFFFF : 16'h0000;
        else t.acc[15:8] = $urandom_range(3) == 0 ? 8'hFF : 8'h00;
      end
      send_instr(t);
    end
    s_axis_tvalid <= 0;
    calm = 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
src/g3mdu_pkg.sv
src/g3mdu_front.sv
src/g3mdu_queue.sv
src/g3mdu_back.sv
src/x86_group3_unary_muldiv_unit.sv
tb/sv/x86_group3_unary_muldiv_unit_tb.sv
